// ===== hw/rtl/n2a_pkg.sv =====
// Package for the number to ASCII formatter.
// Holds the format codes, character constants, queue item type and back-end states.
// No dependencies.
`timescale 1ns / 1ps

package n2a_pkg;

  localparam int FuncW     = 3;
  localparam int ValueW    = 32;
  localparam int DigitCntW = 3;
  localparam int CharW     = 8;
  localparam int MaxChars  = 11;
  localparam int LenW      = $clog2(MaxChars + 1);
  localparam int IdxW      = $clog2(MaxChars);
  localparam int QDepth    = 2;

  localparam logic [FuncW-1:0] FuncUdec   = 3'd0;
  localparam logic [FuncW-1:0] FuncSdec   = 3'd1;
  localparam logic [FuncW-1:0] FuncBinS   = 3'd2;
  localparam logic [FuncW-1:0] FuncBinF   = 3'd3;
  localparam logic [FuncW-1:0] FuncHex    = 3'd4;
  localparam logic [FuncW-1:0] FuncFixDec = 3'd5;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharOne   = 8'h31;
  localparam logic [CharW-1:0] CharSeven = 8'h37;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharLowB  = 8'h62;
  localparam logic [CharW-1:0] CharUpB   = 8'h42;
  localparam logic [CharW-1:0] CharUpX   = 8'h58;

  // Reciprocal of ten for a 32-bit dividend, used with a right shift of 35.
  localparam logic [ValueW-1:0] RecipTen = 32'hCCCC_CCCD;
  localparam int RecipShift = 35;

  typedef enum logic [1:0] {
    KindDec,
    KindFix,
    KindBin,
    KindHex
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              neg;
    logic              upper;
    logic [ValueW-1:0] mag;
    logic [LenW-1:0]   len;
  } item_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkConv,
    BkSign,
    BkEmit
  } back_state_e;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CharZero + {4'd0, nib};
    end else begin
      hex_char = CharSeven + {4'd0, nib};
    end
  endfunction

endpackage

// ===== hw/rtl/n2a_if.sv =====
// Channel interfaces for the number to ASCII formatter.
// Depends on n2a_pkg for the payload widths.
`timescale 1ns / 1ps

interface n2a_in_if;
  logic                           valid;
  logic                           ready;
  logic [n2a_pkg::FuncW-1:0]      func;
  logic [n2a_pkg::ValueW-1:0]     value;
  logic [n2a_pkg::DigitCntW-1:0]  digit_count;

  modport source (output valid, output func, output value, output digit_count, input ready);
  modport sink (input valid, input func, input value, input digit_count, output ready);
endinterface

interface n2a_out_if;
  logic                       valid;
  logic                       ready;
  logic [n2a_pkg::CharW-1:0]  char_code;
  logic                       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

// ===== hw/rtl/number_to_ascii_formatter_core.sv =====
// Top level of the number to ASCII formatter.
// Depends on n2a_pkg, n2a_if, n2a_front, n2a_queue and n2a_back.
`timescale 1ns / 1ps

// Each accepted number is turned into its ASCII text, one character per output
// transfer, with last set on the final character; format codes 6 and 7 are
// accepted and produce no characters. The front end classifies a number in the
// cycle it is accepted, and a queue holds up to two numbers, so input keeps
// flowing while the back end works. The back end handles one number at a time:
// it takes the number from the queue, then for decimal formats produces one digit
// per cycle through a single divide-by-ten unit and adds a minus sign if needed,
// then sends the characters through the output register, one per cycle while the
// output is ready. The longest text is eleven characters, for a signed value.

module number_to_ascii_formatter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  n2a_in_if.sink     in_i,
  n2a_out_if.source  out_o
);
  import n2a_pkg::*;

  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  item_t push_item;
  item_t head_item;

  n2a_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  n2a_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  n2a_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (head_item),
    .pop_o     (pop),
    .out_o     (out_o)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("Push into a full queue.");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("Pop from an empty queue.");

  a_text_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=> out_o.valid)
    else $error("Gap in the characters of one number.");
`endif

endmodule

// ===== hw/rtl/n2a_front.sv =====
// Front end of the number to ASCII formatter: accepts numbers and classifies them.
// Depends on n2a_pkg and n2a_in_if.
`timescale 1ns / 1ps

module n2a_front (
  n2a_in_if.sink          in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output n2a_pkg::item_t  item_o
);
  import n2a_pkg::*;

  logic [7:0] low;
  logic [2:0] lead;
  logic [7:0] aligned;

  assign low = in_i.value[7:0];

  always_comb begin
    lead = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (low[i]) begin
        lead = 3'(i);
      end
    end
  end

  assign aligned = low << (3'd7 - lead);
  assign in_i.ready = !q_full_i;

  always_comb begin
    push_o       = in_i.valid && !q_full_i;
    item_o.kind  = KindDec;
    item_o.neg   = 1'b0;
    item_o.upper = 1'b1;
    item_o.mag   = in_i.value;
    item_o.len   = LenW'(10);
    case (in_i.func)
      FuncUdec: begin
      end
      FuncSdec: begin
        item_o.neg = in_i.value[ValueW-1];
        if (in_i.value[ValueW-1]) begin
          item_o.mag = ValueW'(0) - in_i.value;
        end
      end
      FuncBinS: begin
        item_o.kind = KindBin;
        item_o.mag  = {24'd0, low};
        if (low != 8'd0) begin
          item_o.upper = 1'b0;
          item_o.mag   = {24'd0, aligned};
          item_o.len   = LenW'(3) + LenW'(lead);
        end
      end
      FuncBinF: begin
        item_o.kind = KindBin;
        item_o.mag  = {24'd0, low};
      end
      FuncHex: begin
        item_o.kind = KindHex;
        item_o.mag  = {24'd0, low};
        item_o.len  = LenW'(4);
      end
      FuncFixDec: begin
        item_o.kind = KindFix;
        if (in_i.digit_count <= 3'd2) begin
          item_o.mag = {24'd0, low};
          item_o.len = LenW'(2);
        end else if (in_i.digit_count == 3'd3) begin
          item_o.mag = {16'd0, in_i.value[15:0]};
          item_o.len = LenW'(3);
        end else begin
          item_o.mag = {16'd0, in_i.value[15:0]};
          item_o.len = LenW'(4);
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/n2a_queue.sv =====
// Small queue of classified items between the front and back ends.
// Depends on n2a_pkg.
`timescale 1ns / 1ps

module n2a_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  n2a_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output n2a_pkg::item_t  item_o
);
  import n2a_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  item_t           slot_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QDepth));
  assign valid_o = (count_q != CntW'(0));
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? PtrW'(0) : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? PtrW'(0) : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/n2a_back.sv =====
// Back end of the number to ASCII formatter: converts one item and sends its characters.
// Depends on n2a_pkg and n2a_out_if.
`timescale 1ns / 1ps

module n2a_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  n2a_pkg::item_t  q_item_i,
  output logic            pop_o,
  n2a_out_if.source       out_o
);
  import n2a_pkg::*;

  back_state_e       state_q, state_d;
  logic [CharW-1:0]  buf_q [MaxChars];
  logic [CharW-1:0]  buf_d [MaxChars];
  kind_e             kind_q, kind_d;
  logic              neg_q, neg_d;
  logic [LenW-1:0]   dig_q, dig_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ValueW-1:0] cur_q, cur_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quo;
  logic [ValueW-1:0]   rem_w;
  logic [CharW-1:0]    digit;
  logic                conv_done;
  logic                slot_free;
  logic                at_last;

  assign prod      = (2*ValueW)'(cur_q) * (2*ValueW)'(RecipTen);
  assign quo       = ValueW'(prod >> RecipShift);
  assign rem_w     = cur_q - ((quo << 3) + (quo << 1));
  assign digit     = CharZero + {4'd0, rem_w[3:0]};
  assign conv_done = (kind_q == KindDec) ? (quo == '0) : (len_q + LenW'(1) == dig_q);
  assign slot_free = !out_valid_q || out_o.ready;
  assign at_last   = (LenW'(idx_q) + LenW'(1) == len_q);

  assign pop_o           = (state_q == BkIdle) && q_valid_i;
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = out_char_q;
  assign out_o.last      = out_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          if (q_item_i.kind == KindDec || q_item_i.kind == KindFix) begin
            state_d = BkConv;
          end else begin
            state_d = BkEmit;
          end
        end
      end
      BkConv: begin
        if (conv_done) begin
          state_d = neg_q ? BkSign : BkEmit;
        end
      end
      BkSign: begin
        state_d = BkEmit;
      end
      BkEmit: begin
        if (slot_free && at_last) begin
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_comb begin
    buf_d       = buf_q;
    kind_d      = kind_q;
    neg_d       = neg_q;
    dig_d       = dig_q;
    len_d       = len_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          kind_d = q_item_i.kind;
          neg_d  = q_item_i.neg;
          dig_d  = q_item_i.len;
          cur_d  = q_item_i.mag;
          len_d  = '0;
          idx_d  = '0;
          if (q_item_i.kind == KindBin) begin
            buf_d[0] = CharZero;
            buf_d[1] = q_item_i.upper ? CharUpB : CharLowB;
            for (int j = 0; j < 8; j++) begin
              buf_d[2+j] = q_item_i.mag[7-j] ? CharOne : CharZero;
            end
            len_d = q_item_i.len;
          end else if (q_item_i.kind == KindHex) begin
            buf_d[0] = CharZero;
            buf_d[1] = CharUpX;
            buf_d[2] = hex_char(q_item_i.mag[7:4]);
            buf_d[3] = hex_char(q_item_i.mag[3:0]);
            len_d    = q_item_i.len;
          end
        end
      end
      BkConv: begin
        for (int i = MaxChars - 1; i > 0; i--) begin
          buf_d[i] = buf_q[i-1];
        end
        buf_d[0] = digit;
        len_d    = len_q + LenW'(1);
        cur_d    = quo;
      end
      BkSign: begin
        for (int i = MaxChars - 1; i > 0; i--) begin
          buf_d[i] = buf_q[i-1];
        end
        buf_d[0] = CharMinus;
        len_d    = len_q + LenW'(1);
      end
      BkEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = buf_q[idx_q];
          out_last_d  = at_last;
          idx_d       = idx_q + IdxW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    kind_q     <= kind_d;
    neg_q      <= neg_d;
    dig_q      <= dig_d;
    len_q      <= len_d;
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for number_to_ascii_formatter_core: it drives numbers with
// random gaps, predicts their ASCII text and checks every character transfer.
// Depends on n2a_pkg, n2a_if and the formatter RTL.
`timescale 1ns / 1ps

module tb_top;
  import n2a_pkg::*;

  localparam logic [FuncW-1:0] FuncSpare6 = 3'd6;
  localparam logic [FuncW-1:0] FuncSpare7 = 3'd7;
  localparam int DrainCycles = 40;

  typedef struct {
    logic [FuncW-1:0]     func;
    logic [ValueW-1:0]    value;
    logic [DigitCntW-1:0] digit_count;
    int unsigned          gap;
  } number_item_t;

  typedef struct {
    logic [CharW-1:0] char_code;
    logic             last;
  } text_char_t;

  logic clk_i;
  logic rst_ni;

  n2a_in_if  in_if ();
  n2a_out_if out_if ();

  number_to_ascii_formatter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  number_item_t pending_q[$];
  text_char_t   text_q[$];
  number_item_t next_num;
  int unsigned  idle_left;
  int unsigned  stall_left;
  int unsigned  chars_seen;
  int unsigned  error_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic add_number(input logic [FuncW-1:0] func, input logic [ValueW-1:0] value,
                            input logic [DigitCntW-1:0] digit_count, input int unsigned gap);
    number_item_t num;
    num.func = func;
    num.value = value;
    num.digit_count = digit_count;
    num.gap = gap;
    pending_q.push_back(num);
  endtask

  // Works out the text of one number and queues its characters.
  task automatic format_text(input logic [FuncW-1:0] func, input logic [ValueW-1:0] value,
                             input logic [DigitCntW-1:0] digit_count);
    string            txt;
    logic [7:0]       lo;
    logic [ValueW-1:0] mag;
    logic [3:0]       nib_hi;
    logic [3:0]       nib_lo;
    logic [CharW-1:0] hex_hi;
    logic [CharW-1:0] hex_lo;
    logic [DigitCntW-1:0] width;
    text_char_t       tc;
    txt = "";
    lo = value[7:0];
    case (func)
      FuncUdec: begin
        txt = $sformatf("%0d", value);
      end
      FuncSdec: begin
        if (value[ValueW-1]) begin
          mag = -value;
          txt = $sformatf("-%0d", mag);
        end else begin
          txt = $sformatf("%0d", value);
        end
      end
      FuncBinS: begin
        if (lo == 8'd0) begin
          txt = "0B00000000";
        end else begin
          txt = $sformatf("0b%0b", lo);
        end
      end
      FuncBinF: begin
        txt = $sformatf("0B%08b", lo);
      end
      FuncHex: begin
        nib_hi = lo[7:4];
        nib_lo = lo[3:0];
        hex_hi = (nib_hi < 4'd10) ? CharZero + nib_hi : CharSeven + nib_hi;
        hex_lo = (nib_lo < 4'd10) ? CharZero + nib_lo : CharSeven + nib_lo;
        txt = $sformatf("0X%c%c", hex_hi, hex_lo);
      end
      FuncFixDec: begin
        width = digit_count;
        if (width < 3'd2) width = 3'd2;
        if (width > 3'd4) width = 3'd4;
        if (width == 3'd2) begin
          txt = $sformatf("%02d", lo % 100);
        end else if (width == 3'd3) begin
          txt = $sformatf("%03d", value[15:0] % 1000);
        end else begin
          txt = $sformatf("%04d", value[15:0] % 10000);
        end
      end
      default: begin
        txt = "";
      end
    endcase
    for (int k = 0; k < txt.len(); k++) begin
      tc.char_code = txt[k];
      tc.last = (k == txt.len() - 1);
      text_q.push_back(tc);
    end
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 20);
      2: v = $urandom_range(0, 255);
      3: v = $urandom() & 32'hFFFF_FF00;
      4: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'd0;
          4: v = 32'd9999;
          default: v = 32'd1_000_000_000;
        endcase
      end
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  function automatic logic [FuncW-1:0] rand_func();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 18) return FuncW'(r / 3);
    return (r == 18) ? FuncSpare6 : FuncSpare7;
  endfunction

  // Input side: one number per transfer, with a drawn number of idle cycles after it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.func <= '0;
      in_if.value <= '0;
      in_if.digit_count <= '0;
      idle_left <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        format_text(in_if.func, in_if.value, in_if.digit_count);
      end
      if (!in_if.valid || in_if.ready) begin
        if (idle_left != 0) begin
          in_if.valid <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending_q.size() != 0) begin
          next_num = pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.func <= next_num.func;
          in_if.value <= next_num.value;
          in_if.digit_count <= next_num.digit_count;
          idle_left <= next_num.gap;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each character transfer and stalls a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    int unsigned stall;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      chars_seen <= 0;
    end else if (out_if.valid && out_if.ready) begin
      chars_seen <= chars_seen + 1;
      if (text_q.size() == 0) begin
        error_count <= error_count + 1;
        $display("%0t: unexpected character: expected none, actual char 0x%02h last %0b",
                 $time, out_if.char_code, out_if.last);
      end else begin
        want = text_q.pop_front();
        if (want.char_code !== out_if.char_code || want.last !== out_if.last) begin
          error_count <= error_count + 1;
          if (want.char_code !== out_if.char_code) begin
            $display("%0t: char_code mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want.char_code, out_if.char_code);
          end
          if (want.last !== out_if.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_if.last);
          end
        end
      end
      stall = ((chars_seen % 120) < 30) ? 0 : $urandom_range(0, 3);
      out_if.ready <= (stall == 0);
      stall_left <= (stall == 0) ? 0 : stall - 1;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned gap;
    in_if.valid = 1'b0;
    in_if.func = '0;
    in_if.value = '0;
    in_if.digit_count = '0;
    out_if.ready = 1'b0;
    error_count = 0;
    rst_ni = 1'b0;

    add_number(FuncUdec, 32'd0, 3'd0, 0);
    add_number(FuncUdec, 32'hFFFF_FFFF, 3'd7, 1);
    add_number(FuncUdec, 32'd1_000_000_000, 3'd2, 0);
    add_number(FuncSdec, 32'd0, 3'd0, 2);
    add_number(FuncSdec, 32'h8000_0000, 3'd0, 0);
    add_number(FuncSdec, 32'h7FFF_FFFF, 3'd5, 3);
    add_number(FuncSdec, 32'hFFFF_FFFF, 3'd1, 0);
    add_number(FuncBinS, 32'hABCD_EF00, 3'd0, 0);
    add_number(FuncBinS, 32'h0000_0001, 3'd0, 1);
    add_number(FuncBinS, 32'h0000_00FF, 3'd0, 0);
    add_number(FuncBinS, 32'h5555_5580, 3'd0, 0);
    add_number(FuncBinF, 32'd0, 3'd0, 2);
    add_number(FuncBinF, 32'hFFFF_FF5A, 3'd0, 0);
    add_number(FuncHex, 32'd0, 3'd0, 0);
    add_number(FuncHex, 32'h0000_00FF, 3'd0, 1);
    add_number(FuncHex, 32'h1234_569A, 3'd0, 0);
    add_number(FuncFixDec, 32'hFFFF_FFFF, 3'd0, 0);
    add_number(FuncFixDec, 32'h0000_0005, 3'd1, 0);
    add_number(FuncFixDec, 32'h0000_00FF, 3'd2, 3);
    add_number(FuncFixDec, 32'h0000_FFFF, 3'd3, 0);
    add_number(FuncFixDec, 32'h0000_FFFF, 3'd4, 0);
    add_number(FuncFixDec, 32'h0000_0007, 3'd5, 1);
    add_number(FuncFixDec, 32'hAAAA_2710, 3'd7, 0);
    add_number(FuncSpare6, 32'hFFFF_FFFF, 3'd7, 0);
    add_number(FuncSpare7, 32'h1234_5678, 3'd3, 0);

    for (int i = 0; i < 145; i++) begin
      gap = ((i >= 50 && i < 80) || (i >= 120 && i < 140)) ? 0 : $urandom_range(0, 3);
      add_number(rand_func(), rand_value(), DigitCntW'($urandom_range(0, 7)), gap);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_if.valid || text_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && text_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== number_to_ascii_formatter_core.f =====
hw/rtl/n2a_pkg.sv
hw/rtl/n2a_if.sv
hw/rtl/n2a_front.sv
hw/rtl/n2a_queue.sv
hw/rtl/n2a_back.sv
hw/rtl/number_to_ascii_formatter_core.sv
verif/tb_top.sv
